@@ rtl/core/dra_pkg.sv @@
// ----------------------------------------------------------------------------
// dra_pkg
// Shared types, constants and helpers of the descriptor ring / byte ring
// message allocator.
// ----------------------------------------------------------------------------
package dra_pkg;

    // Ring geometry
    localparam int RING_SLOTS = 64;
    localparam int BLOB_BYTES = 65536;
    localparam int UNIT       = 8;

    localparam int IDX_W  = $clog2(RING_SLOTS);
    // Byte head and tail count modulo twice the ring size
    localparam int SPAN   = 2 * BLOB_BYTES;
    localparam int PTR_W  = $clog2(SPAN);
    localparam int OFF_W  = $clog2(BLOB_BYTES);
    localparam int SIZE_W = $clog2(BLOB_BYTES + 1);
    // Working width for sizes, sums and compares (payload size is 24 bits)
    localparam int CALC_W = (PTR_W + 2 > 26) ? PTR_W + 2 : 26;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_DROPPED   = 3'd2,
        STAT_RING_FULL = 3'd3,
        STAT_TOO_LARGE = 3'd4,
        STAT_NO_SPACE  = 3'd5
    } dra_status_t;

    // Slot states
    typedef enum logic [1:0] {
        SLOT_FREE      = 2'd0,
        SLOT_PUBLISHED = 2'd1,
        SLOT_DROPPED   = 2'd2
    } dra_slot_t;

    // Operation codes
    localparam logic OP_SEND = 1'b0;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } dra_state_t;

    // Input transfer payload
    typedef struct packed {
        logic        op;
        logic [15:0] src_node;
        logic [31:0] label;
        logic [31:0] app_seq;
        logic [23:0] payload_size;
    } dra_in_t;

    // Result transfer payload
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_src_node;
        logic [31:0] out_label;
        logic [31:0] out_app_seq;
        logic [15:0] out_offset;
        logic [16:0] out_size;
    } dra_out_t;

    // Descriptor memory word
    typedef struct packed {
        logic [15:0]       source;
        logic [31:0]       label;
        logic [31:0]       app_seq;
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
    } dra_desc_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic capture;  // input transfer taken, latch item and read descriptor
        logic commit;   // finish the item: update state, load result register
    } dra_cmd_t;

    // Modular add on the doubled byte span (x < SPAN, d <= SPAN)
    function automatic logic [PTR_W-1:0] span_add(input logic [CALC_W-1:0] x,
                                                  input logic [CALC_W-1:0] d);
        logic [CALC_W-1:0] r;
        r = x + d;
        if (r >= CALC_W'(SPAN)) begin
            r = r - CALC_W'(SPAN);
        end
        return r[PTR_W-1:0];
    endfunction

    // Round a byte count up to whole allocation units
    function automatic logic [CALC_W-1:0] round_unit(input logic [CALC_W-1:0] x);
        return (x + CALC_W'(UNIT - 1)) & ~CALC_W'(UNIT - 1);
    endfunction

    // Position inside the byte ring of a doubled-span pointer
    function automatic logic [CALC_W-1:0] ring_pos(input logic [PTR_W-1:0] p);
        logic [CALC_W-1:0] x;
        x = CALC_W'(p);
        if (x >= CALC_W'(BLOB_BYTES)) begin
            x = x - CALC_W'(BLOB_BYTES);
        end
        return x;
    endfunction

    // Next ring slot
    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(RING_SLOTS - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

@@ rtl/core/dra_ctrl.sv @@
// ----------------------------------------------------------------------------
// dra_ctrl
// Two-state controller: takes one item, executes it and hands the result to
// the output register, stalling while that register is still occupied.
// ----------------------------------------------------------------------------
module dra_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output dra_pkg::dra_cmd_t cmd
);

    dra_pkg::dra_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;

    // State and result-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dra_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            dra_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = dra_pkg::ST_EXEC;
                end
            end
            dra_pkg::ST_EXEC: begin
                // finish only when the result register is free or draining
                if (!out_valid_reg || m_ready) begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = dra_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dra_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_commit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("result not valid after commit");
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == dra_pkg::ST_EXEC) && !s_ready)
        else $error("accepted transfer did not start execution");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dra_pkg::ST_EXEC && m_valid && !m_ready)
        |=> (state_reg == dra_pkg::ST_EXEC) && m_valid)
        else $error("item finished while result register was blocked");
    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.capture && cmd.commit))
        else $error("capture and commit in the same cycle");
`endif

endmodule

@@ rtl/core/dra_datapath.sv @@
// ----------------------------------------------------------------------------
// dra_datapath
// Slot status flags, descriptor memory, ring pointers, allocation arithmetic
// and the result register.
// ----------------------------------------------------------------------------
module dra_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  dra_pkg::dra_cmd_t cmd,
    input  dra_pkg::dra_in_t  s_data,
    output dra_pkg::dra_out_t m_data
);

    localparam int CW = dra_pkg::CALC_W;
    localparam int PW = dra_pkg::PTR_W;
    localparam int IW = dra_pkg::IDX_W;
    localparam int NS = dra_pkg::RING_SLOTS;

    localparam logic [CW-1:0] BLOB = CW'(dra_pkg::BLOB_BYTES);
    localparam logic [CW-1:0] SPAN = CW'(dra_pkg::SPAN);

    // Control state
    dra_pkg::dra_slot_t slot_st_reg [NS];
    dra_pkg::dra_slot_t slot_st_next[NS];
    logic [IW-1:0]      wr_idx_reg, wr_idx_next;
    logic [IW-1:0]      rd_idx_reg, rd_idx_next;
    logic [PW-1:0]      head_reg, head_next;
    logic [PW-1:0]      tail_reg, tail_next;

    // Item and pre-computed terms latched at capture
    dra_pkg::dra_in_t   item_reg;
    logic [CW-1:0]      rsv_reg, used_reg, hoff_reg, toff_reg;
    dra_pkg::dra_desc_t rd_data_reg;
    dra_pkg::dra_slot_t wr_st_reg, rd_st_reg;
    dra_pkg::dra_out_t  out_reg, out_next;

    // Descriptor memory
    dra_pkg::dra_desc_t mem [NS];
    logic               mem_we;
    dra_pkg::dra_desc_t mem_wdata;

    // Capture-cycle terms
    logic [CW-1:0] rsv_c, used_c;

    // Execute-cycle terms
    logic [CW-1:0]     pad, used2, head_base_off, rx_rsv, tail_skip_d;
    logic [PW-1:0]     head_pad, head_base, tail_mid;
    logic              too_large, no_space1, no_space2, wrap;

    always_comb begin
        rsv_c  = dra_pkg::round_unit(CW'(s_data.payload_size));
        used_c = (head_reg >= tail_reg) ? CW'(head_reg) - CW'(tail_reg)
                                        : CW'(head_reg) + SPAN - CW'(tail_reg);
    end

    // Capture registers, slot status and descriptor reads
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg    <= s_data;
            rsv_reg     <= rsv_c;
            used_reg    <= used_c;
            hoff_reg    <= dra_pkg::ring_pos(head_reg);
            toff_reg    <= dra_pkg::ring_pos(tail_reg);
            rd_data_reg <= mem[rd_idx_reg];
            wr_st_reg   <= slot_st_reg[wr_idx_reg];
            rd_st_reg   <= slot_st_reg[rd_idx_reg];
        end
    end

    // Descriptor write
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_idx_reg] <= mem_wdata;
        end
    end

    // Allocation checks for a send
    always_comb begin
        too_large     = rsv_reg > BLOB;
        no_space1     = (used_reg + rsv_reg) > BLOB;
        wrap          = (hoff_reg + rsv_reg) > BLOB;
        pad           = BLOB - hoff_reg;
        head_pad      = dra_pkg::span_add(CW'(head_reg), pad);
        used2         = used_reg + pad;
        no_space2     = (used2 + rsv_reg) > BLOB;
        head_base     = wrap ? head_pad : head_reg;
        head_base_off = wrap ? '0 : hoff_reg;
    end

    // Tail movement for a published receive
    always_comb begin
        rx_rsv = dra_pkg::round_unit(CW'(rd_data_reg.size));
        if (rx_rsv > BLOB) begin
            rx_rsv = BLOB;
        end
        tail_skip_d = BLOB - toff_reg;
        tail_mid    = (toff_reg != CW'(rd_data_reg.offset))
                    ? dra_pkg::span_add(CW'(tail_reg), tail_skip_d) : tail_reg;
    end

    // Execute: next state, memory write and result
    always_comb begin
        slot_st_next = slot_st_reg;
        wr_idx_next  = wr_idx_reg;
        rd_idx_next  = rd_idx_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        out_next     = out_reg;
        mem_we       = 1'b0;
        mem_wdata    = '0;
        mem_wdata.source = item_reg.src_node;
        mem_wdata.label  = item_reg.label;

        if (cmd.commit) begin
            out_next = '0;
            if (item_reg.op == dra_pkg::OP_SEND) begin
                if (wr_st_reg != dra_pkg::SLOT_FREE) begin
                    out_next.status = dra_pkg::STAT_RING_FULL;
                end else if (too_large || no_space1 || (wrap && no_space2)) begin
                    // publish a dropped descriptor; wrap padding stays applied
                    mem_we                   = 1'b1;
                    slot_st_next[wr_idx_reg] = dra_pkg::SLOT_DROPPED;
                    wr_idx_next              = dra_pkg::next_index(wr_idx_reg);
                    if (!too_large && !no_space1) begin
                        head_next = head_pad;
                    end
                    out_next.status       = too_large ? dra_pkg::STAT_TOO_LARGE
                                                      : dra_pkg::STAT_NO_SPACE;
                    out_next.out_src_node = item_reg.src_node;
                    out_next.out_label    = item_reg.label;
                end else begin
                    // allocate at the (possibly padded) head
                    mem_we                   = 1'b1;
                    mem_wdata.app_seq        = item_reg.app_seq;
                    mem_wdata.offset         = dra_pkg::OFF_W'(head_base_off);
                    mem_wdata.size           = dra_pkg::SIZE_W'(item_reg.payload_size);
                    slot_st_next[wr_idx_reg] = dra_pkg::SLOT_PUBLISHED;
                    wr_idx_next              = dra_pkg::next_index(wr_idx_reg);
                    head_next                = dra_pkg::span_add(CW'(head_base), rsv_reg);
                    out_next.status          = dra_pkg::STAT_OK;
                    out_next.out_offset      = 16'(head_base_off);
                end
            end else begin
                case (rd_st_reg)
                    dra_pkg::SLOT_FREE: begin
                        out_next.status = dra_pkg::STAT_EMPTY;
                    end
                    dra_pkg::SLOT_DROPPED: begin
                        out_next.status       = dra_pkg::STAT_DROPPED;
                        out_next.out_src_node = rd_data_reg.source;
                        out_next.out_label    = rd_data_reg.label;
                        slot_st_next[rd_idx_reg] = dra_pkg::SLOT_FREE;
                        rd_idx_next = dra_pkg::next_index(rd_idx_reg);
                    end
                    default: begin
                        out_next.status       = dra_pkg::STAT_OK;
                        out_next.out_src_node = rd_data_reg.source;
                        out_next.out_label    = rd_data_reg.label;
                        out_next.out_app_seq  = rd_data_reg.app_seq;
                        out_next.out_offset   = 16'(rd_data_reg.offset);
                        out_next.out_size     = 17'(rd_data_reg.size);
                        tail_next = dra_pkg::span_add(CW'(tail_mid), rx_rsv);
                        slot_st_next[rd_idx_reg] = dra_pkg::SLOT_FREE;
                        rd_idx_next = dra_pkg::next_index(rd_idx_reg);
                    end
                endcase
            end
        end
    end

    // Control state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS; i++) begin
                slot_st_reg[i] <= dra_pkg::SLOT_FREE;
            end
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
        end else begin
            slot_st_reg <= slot_st_next;
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_data = out_reg;

endmodule

@@ rtl/core/descriptor_ring_blob_allocator.sv @@
// ----------------------------------------------------------------------------
// descriptor_ring_blob_allocator
// Message queue engine: descriptor slot ring plus an 8-byte-unit byte ring.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one item per transfer. op = 0 sends a message (takes the
//   next slot and allocates payload space), op = 1 receives the next message
//   (returns empty, dropped or published descriptor and frees the slot).
//   m_* channel: exactly one result transfer per input transfer, in order.
//   Flow: the input item and the descriptor memory read are registered at
//   capture; execute then does the allocation and descriptor write and loads
//   the result register, waiting while that register is still occupied. A new
//   item is not taken until execute has finished the current one.
//   s_ready is high whenever the engine is waiting for an item; a result
//   still waiting on m_ready does not block the next input transfer, but
//   that item stays in execute until the result register drains.
//   Reset (aresetn low, synchronous): all slots free, indices and byte
//   pointers zero; descriptor memory contents are not cleared and there is
//   no clearing pass, so the engine is ready the cycle after reset.
// ----------------------------------------------------------------------------
module descriptor_ring_blob_allocator (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dra_pkg::dra_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dra_pkg::dra_out_t m_data
);

    dra_pkg::dra_cmd_t cmd;

    // Sequencer
    dra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Rings, memory and result register
    dra_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule
